// File: hw/rtl/pairwise_separation_defines.svh
// Assertion macros for the pairwise separation block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PAIRWISE_SEPARATION_DEFINES_SVH
`define PAIRWISE_SEPARATION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PWS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PWS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/pws_pkg.sv
// Shared constants and types for the pairwise separation block.
// No dependencies.
package pws_pkg;

  localparam int MAX_AGENTS_DEF = 32;
  localparam int COORD_BITS_DEF = 24;

  // Fixed result field widths
  localparam int IDX_W   = 5;
  localparam int DELTA_W = 25;
  localparam int DIST_W  = 50;

  // Axis select for the shared squaring unit
  typedef logic [1:0] axis_t;
  localparam axis_t AX_X = 2'd0;
  localparam axis_t AX_Y = 2'd1;
  localparam axis_t AX_Z = 2'd2;

endpackage

// File: hw/rtl/pairwise_separation.sv
// Pairwise separation: stores agent points and emits one result per earlier agent.
// Depends on pws_pkg and pairwise_separation_defines.svh.
//
//   port group   dir   handshake            payload
//   in_*         in    in_valid/in_ready    start_frame, pos_x/y/z
//   out_*        out   out_valid/out_ready  indices, delta_x/y/z, dist_squared, last_pair
//
// A point stored as agent j is accepted and then paired with each earlier agent
// in turn: read, subtract, three squaring steps on the one shared multiplier,
// output.
// Stalls on out_ready stretch the output step; in_ready is low while pairing.
// Reset clears the agent count and sequencer; the point store needs no clear.
`include "pairwise_separation_defines.svh"

module pairwise_separation
  import pws_pkg::*;
#(
  parameter int MAX_AGENTS = MAX_AGENTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_start_frame,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [IDX_W-1:0]             out_earlier_index,
  output logic [IDX_W-1:0]             out_newer_index,
  output logic signed [DELTA_W-1:0]    out_delta_x,
  output logic signed [DELTA_W-1:0]    out_delta_y,
  output logic signed [DELTA_W-1:0]    out_delta_z,
  output logic [DIST_W-1:0]            out_dist_squared,
  output logic                         out_last_pair
);

  localparam int IW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int CW = $clog2(MAX_AGENTS + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int MW = 3 * COORD_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_SQ,
    ST_OUT
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       cnt_r;
  logic [IW-1:0]       i_r;
  logic [IW-1:0]       j_r;
  axis_t               ax_r;
  logic                last_r;
  logic signed [COORD_BITS-1:0] nx_r, ny_r, nz_r;
  logic signed [DW-1:0] dx_r, dy_r, dz_r;
  logic [DIST_W-1:0]   acc_r;

  logic [MW-1:0]       mem [MAX_AGENTS];
  logic [MW-1:0]       rd_data_r;

  logic                in_xfer;
  logic                out_xfer;
  logic [CW-1:0]       cnt_eff;
  logic                wr_en;
  logic signed [COORD_BITS-1:0] ox, oy, oz;
  logic signed [DW-1:0] dsel;
  logic [DW-1:0]       mag;
  logic [2*DW-1:0]     prod;
  logic [DIST_W-1:0]   acc_base;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign cnt_eff  = in_start_frame ? '0 : cnt_r;
  assign wr_en    = in_xfer && (cnt_eff < CW'(MAX_AGENTS));

  // Point store: written on accept while not full, read one earlier agent per pair
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cnt_eff[IW-1:0]] <= {in_pos_x, in_pos_y, in_pos_z};
    end
    rd_data_r <= mem[i_r];
  end

  assign ox = $signed(rd_data_r[MW-1:2*COORD_BITS]);
  assign oy = $signed(rd_data_r[2*COORD_BITS-1:COORD_BITS]);
  assign oz = $signed(rd_data_r[COORD_BITS-1:0]);

  // Shared squaring unit
  always_comb begin
    case (ax_r)
      AX_X:    dsel = dx_r;
      AX_Y:    dsel = dy_r;
      AX_Z:    dsel = dz_r;
      default: dsel = dz_r;
    endcase
    mag      = dsel[DW-1] ? DW'(-dsel) : DW'(dsel);
    prod     = mag * mag;
    acc_base = (ax_r == AX_X) ? '0 : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      i_r     <= '0;
      ax_r    <= AX_X;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (cnt_eff < CW'(MAX_AGENTS)) begin
              cnt_r <= cnt_eff + CW'(1);
              j_r   <= cnt_eff[IW-1:0];
              i_r   <= '0;
              nx_r  <= in_pos_x;
              ny_r  <= in_pos_y;
              nz_r  <= in_pos_z;
              if (cnt_eff != '0) begin
                state_r <= ST_READ;
              end
            end else begin
              cnt_r <= cnt_eff;
            end
          end
        end
        ST_READ: begin
          state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          dx_r    <= DW'(nx_r) - DW'(ox);
          dy_r    <= DW'(ny_r) - DW'(oy);
          dz_r    <= DW'(nz_r) - DW'(oz);
          ax_r    <= AX_X;
          state_r <= ST_SQ;
        end
        ST_SQ: begin
          acc_r <= acc_base + DIST_W'(prod);
          if (ax_r == AX_Z) begin
            ax_r    <= AX_X;
            last_r  <= (i_r + IW'(1) == j_r);
            state_r <= ST_OUT;
          end else begin
            ax_r <= ax_r + axis_t'(1);
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            if (last_r) begin
              state_r <= ST_IDLE;
            end else begin
              i_r     <= i_r + IW'(1);
              state_r <= ST_READ;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid         = (state_r == ST_OUT);
  assign out_earlier_index = IDX_W'(i_r);
  assign out_newer_index   = IDX_W'(j_r);
  assign out_delta_x       = DELTA_W'(dx_r);
  assign out_delta_y       = DELTA_W'(dy_r);
  assign out_delta_z       = DELTA_W'(dz_r);
  assign out_dist_squared  = acc_r;
  assign out_last_pair     = last_r;

  `PWS_ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready, "in_ready during output")
  `PWS_ASSERT_IMPL(a_last_index, clk, rst_n, out_valid && out_last_pair,
    out_newer_index == out_earlier_index + IDX_W'(1), "last pair index mismatch")
  `PWS_ASSERT_NEXT(a_last_idle, clk, rst_n, out_xfer && out_last_pair, in_ready,
    "not idle after last pair")
  `PWS_ASSERT_NEXT(a_more_pairs, clk, rst_n, out_xfer && !out_last_pair,
    !out_valid && !in_ready, "bad step after non-final pair")
  `PWS_ASSERT_IMPL(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CW'(MAX_AGENTS),
    "agent count beyond capacity")

endmodule
